### rtl/core/hsoc_pkg.sv
`default_nettype none

package hsoc_pkg;

  localparam int unsigned DefTableEntries = 256;
  localparam int unsigned DefKeyWidth     = 32;
  localparam int unsigned DefCountWidth   = 16;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned ReqKeyW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OutKeyW = 32;
  localparam int unsigned SetOpW  = 2;

  // request function codes
  localparam logic [FuncW-1:0] FUNC_LEFT    = 3'd0;
  localparam logic [FuncW-1:0] FUNC_RIGHT   = 3'd1;
  localparam logic [FuncW-1:0] FUNC_FETCH   = 3'd2;
  localparam logic [FuncW-1:0] FUNC_RESTART = 3'd3;
  localparam logic [FuncW-1:0] FUNC_CLEAR   = 3'd4;

  // result status codes
  localparam logic [StatusW-1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL     = 2'd1;
  localparam logic [StatusW-1:0] STAT_ROW      = 2'd2;
  localparam logic [StatusW-1:0] STAT_END      = 2'd3;

  // set operations
  localparam logic [SetOpW-1:0] OP_INTERSECT     = 2'd0;
  localparam logic [SetOpW-1:0] OP_INTERSECT_ALL = 2'd1;
  localparam logic [SetOpW-1:0] OP_EXCEPT        = 2'd2;
  localparam logic [SetOpW-1:0] OP_EXCEPT_ALL    = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [ReqKeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [OutKeyW-1:0] out_key;
  } rsp_t;

  // controller to datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_ACK,
    CMD_RESTART,
    CMD_CLEAR,
    CMD_READ,
    CMD_NEXT,
    CMD_LEFT_HIT,
    CMD_RIGHT_HIT,
    CMD_INSERT,
    CMD_FULL,
    CMD_EMIT_COPY,
    CMD_END,
    CMD_SCAN_END,
    CMD_SCAN_STEP
  } cmd_e;

  // datapath to controller status
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             at_end;
    logic             full;
    logic             match;
    logic             copies_nz;
    logic             done;
    logic             count_nz;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/hsoc_ctrl.sv
`default_nettype none

module hsoc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire hsoc_pkg::dp_stat_t stat_i,
  output hsoc_pkg::cmd_e         cmd_o
);
  import hsoc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_CMP   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = CMD_CAPTURE;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (stat_i.func)
          FUNC_LEFT, FUNC_RIGHT: state_d = S_PROBE;
          FUNC_FETCH: begin
            if (stat_i.copies_nz) cmd_o = CMD_EMIT_COPY;
            else if (stat_i.done) cmd_o = CMD_END;
            else state_d = S_PROBE;
          end
          FUNC_RESTART: cmd_o = CMD_RESTART;
          FUNC_CLEAR:   cmd_o = CMD_CLEAR;
          default:      cmd_o = CMD_ACK;
        endcase
      end
      S_PROBE: begin
        if (stat_i.at_end) begin
          state_d = S_IDLE;
          case (stat_i.func)
            FUNC_LEFT:  cmd_o = stat_i.full ? CMD_FULL : CMD_INSERT;
            FUNC_FETCH: cmd_o = CMD_SCAN_END;
            default:    cmd_o = CMD_ACK;
          endcase
        end else begin
          cmd_o   = CMD_READ;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_PROBE;
        case (stat_i.func)
          FUNC_FETCH: begin
            cmd_o = CMD_SCAN_STEP;
            if (stat_i.count_nz) state_d = S_IDLE;
          end
          default: begin
            if (stat_i.match) begin
              cmd_o   = (stat_i.func == FUNC_LEFT) ? CMD_LEFT_HIT : CMD_RIGHT_HIT;
              state_d = S_IDLE;
            end else begin
              cmd_o = CMD_NEXT;
            end
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

### rtl/core/hsoc_dp.sv
`default_nettype none

module hsoc_dp #(
  parameter int unsigned TableEntries = hsoc_pkg::DefTableEntries,
  parameter int unsigned KeyWidth     = hsoc_pkg::DefKeyWidth,
  parameter int unsigned CountWidth   = hsoc_pkg::DefCountWidth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire hsoc_pkg::cmd_e             cmd_i,
  input  wire hsoc_pkg::req_t             req_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [hsoc_pkg::SetOpW-1:0] cfg_data_i,
  output hsoc_pkg::dp_stat_t              stat_o,
  output logic                            rsp_valid_o,
  output hsoc_pkg::rsp_t                  rsp_o
);
  import hsoc_pkg::*;

  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned FillW = $clog2(TableEntries + 1);

  logic [KeyWidth-1:0]   key_mem  [TableEntries];
  logic [CountWidth-1:0] lcnt_mem [TableEntries];
  logic [CountWidth-1:0] rcnt_mem [TableEntries];

  logic [SetOpW-1:0]     set_op_q;
  logic [FuncW-1:0]      func_q;
  logic [KeyWidth-1:0]   key_q;
  logic [FillW-1:0]      fill_q, idx_q, scan_q;
  logic [CountWidth-1:0] copies_q;
  logic [KeyWidth-1:0]   cur_key_q;
  logic                  done_q;
  logic [KeyWidth-1:0]   rd_key_q;
  logic [CountWidth-1:0] rd_l_q, rd_r_q;
  logic                  rsp_valid_q;
  rsp_t                  rsp_q;

  logic [FillW-1:0]      ptr;
  logic [IdxW-1:0]       addr;
  logic [CountWidth-1:0] n_copies, l_inc, r_inc;

  assign ptr  = (func_q == FUNC_FETCH) ? scan_q : idx_q;
  assign addr = ptr[IdxW-1:0];

  assign l_inc = (rd_l_q == '1) ? rd_l_q : rd_l_q + 1'b1;
  assign r_inc = (rd_r_q == '1) ? rd_r_q : rd_r_q + 1'b1;

  always_comb begin
    case (set_op_q)
      OP_INTERSECT:
        n_copies = CountWidth'((rd_l_q != '0) && (rd_r_q != '0));
      OP_INTERSECT_ALL:
        n_copies = (rd_l_q < rd_r_q) ? rd_l_q : rd_r_q;
      OP_EXCEPT:
        n_copies = CountWidth'((rd_l_q != '0) && (rd_r_q == '0));
      default:
        n_copies = (rd_l_q < rd_r_q) ? '0 : rd_l_q - rd_r_q;
    endcase
  end

  always_comb begin
    stat_o.func      = func_q;
    stat_o.at_end    = (ptr == fill_q);
    stat_o.full      = (fill_q == FillW'(TableEntries));
    stat_o.match     = (rd_key_q == key_q);
    stat_o.copies_nz = (copies_q != '0);
    stat_o.done      = done_q;
    stat_o.count_nz  = (n_copies != '0);
  end

  // table storage, no reset: only entries below the fill count are read
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_READ: begin
        rd_key_q <= key_mem[addr];
        rd_l_q   <= lcnt_mem[addr];
        rd_r_q   <= rcnt_mem[addr];
      end
      CMD_LEFT_HIT:  lcnt_mem[addr] <= l_inc;
      CMD_RIGHT_HIT: rcnt_mem[addr] <= r_inc;
      CMD_INSERT: begin
        key_mem[fill_q[IdxW-1:0]]  <= key_q;
        lcnt_mem[fill_q[IdxW-1:0]] <= CountWidth'(1);
        rcnt_mem[fill_q[IdxW-1:0]] <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_CAPTURE) begin
      func_q <= req_i.func;
      key_q  <= KeyWidth'(req_i.key);
    end
    if (cmd_i == CMD_SCAN_STEP && n_copies != '0) cur_key_q <= rd_key_q;
    rsp_q.status  <= STAT_ACCEPTED;
    rsp_q.out_key <= '0;
    case (cmd_i)
      CMD_FULL:      rsp_q.status <= STAT_FULL;
      CMD_END:       rsp_q.status <= STAT_END;
      CMD_SCAN_END:  rsp_q.status <= STAT_END;
      CMD_EMIT_COPY: begin
        rsp_q.status  <= STAT_ROW;
        rsp_q.out_key <= OutKeyW'(cur_key_q);
      end
      CMD_SCAN_STEP: begin
        rsp_q.status  <= STAT_ROW;
        rsp_q.out_key <= OutKeyW'(rd_key_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_op_q    <= OP_INTERSECT;
      fill_q      <= '0;
      idx_q       <= '0;
      scan_q      <= '0;
      copies_q    <= '0;
      done_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) set_op_q <= cfg_data_i;
      rsp_valid_q <= 1'b0;
      case (cmd_i)
        CMD_CAPTURE: idx_q <= '0;
        CMD_NEXT:    idx_q <= idx_q + 1'b1;
        CMD_ACK, CMD_LEFT_HIT, CMD_RIGHT_HIT, CMD_FULL, CMD_END:
          rsp_valid_q <= 1'b1;
        CMD_RESTART: begin
          scan_q      <= '0;
          copies_q    <= '0;
          done_q      <= 1'b0;
          rsp_valid_q <= 1'b1;
        end
        CMD_CLEAR: begin
          fill_q      <= '0;
          scan_q      <= '0;
          copies_q    <= '0;
          done_q      <= 1'b0;
          rsp_valid_q <= 1'b1;
        end
        CMD_INSERT: begin
          fill_q      <= fill_q + 1'b1;
          rsp_valid_q <= 1'b1;
        end
        CMD_EMIT_COPY: begin
          copies_q    <= copies_q - 1'b1;
          rsp_valid_q <= 1'b1;
        end
        CMD_SCAN_END: begin
          done_q      <= 1'b1;
          rsp_valid_q <= 1'b1;
        end
        CMD_SCAN_STEP: begin
          scan_q <= scan_q + 1'b1;
          if (n_copies != '0) begin
            copies_q    <= n_copies - 1'b1;
            rsp_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(TableEntries))
    else $error("fill count beyond table size");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= fill_q)
    else $error("scan index beyond fill count");

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.status != STAT_ROW) |-> (rsp_q.out_key == '0))
    else $error("nonzero key on a non-row result");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_INSERT) |-> (fill_q < FillW'(TableEntries)))
    else $error("insert into full table");

endmodule

`default_nettype wire

### rtl/core/hashed_set_op_counter_top.sv
`default_nettype none

// Set-operation engine (intersect / intersect all / except / except all).
// Requests: raise start with req_i (func, key) while busy is low; the request
// is taken at that edge and busy stays high until the result is out.
// Results: rsp_valid_o is high for exactly one cycle with rsp_o (status,
// out_key); the receiver cannot stall, so results are never held back.
// busy falls in the same cycle as the strobe, so the next request may
// start right then.
// Sequencing: restart, clear, unused codes and fetches of remaining copies
// finish in the execute state. A left or right key reads and compares one
// table entry at a time until a hit or the end of the table. A fetch that
// moves the scan steps through the entries until one gives a row or the
// scan runs off the end of the table; the single-port table memory is read
// one entry at a time.
// Configuration: cfg_we_i with cfg_data_i writes the set operation; write
// only while busy is low and no result is pending.
// Reset: table empty, scan restarted, operation intersect. The table memory
// itself is not cleared; entries beyond the fill count are never read.
module hashed_set_op_counter_top #(
  parameter int unsigned TableEntries = hsoc_pkg::DefTableEntries,
  parameter int unsigned KeyWidth     = hsoc_pkg::DefKeyWidth,
  parameter int unsigned CountWidth   = hsoc_pkg::DefCountWidth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire hsoc_pkg::req_t              req_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [hsoc_pkg::SetOpW-1:0] cfg_data_i,
  output logic                             rsp_valid_o,
  output hsoc_pkg::rsp_t                   rsp_o
);
  import hsoc_pkg::*;

  cmd_e     cmd;
  dp_stat_t stat;

  hsoc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  hsoc_dp #(
    .TableEntries (TableEntries),
    .KeyWidth     (KeyWidth),
    .CountWidth   (CountWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
